@@ sv/ong_pkg.sv @@
// Shared types, constants and step tables for the octant neighborhood gather block.
// Used by ong_ctrl, ong_dpath and octant_neighborhood_gather_core; no dependencies.
package ong_pkg;

  localparam int DEF_MAX_BOARD  = 21;
  localparam int DEF_RING_LIMIT = 4;

  localparam int ROW_W   = 5;
  localparam int RAD_W   = 3;
  localparam int COLOR_W = 2;
  localparam int POS_W   = 7;

  localparam logic [ROW_W-1:0]   SIZE_RESET  = 5'd19;
  localparam logic [COLOR_W-1:0] EMPTY_RESET = 2'd0;

  localparam logic REG_BOARD_SIZE = 1'b0;
  localparam logic REG_EMPTY_CODE = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] SIDE_LAST = 2'd3;

  localparam logic signed [POS_W-1:0] POS_ONE = 7'sd1;
  localparam logic signed [POS_W-1:0] POS_TWO = 7'sd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GATHER
  } state_t;

  typedef struct packed {
    logic               opcode;
    logic [ROW_W-1:0]   cell_row;
    logic [ROW_W-1:0]   cell_col;
    logic [COLOR_W-1:0] cell_value;
    logic [RAD_W-1:0]   radius;
  } item_t;

  typedef struct packed {
    logic clear_wr;
    logic in_ready;
    logic cell_write;
    logic load_query;
    logic push_bad;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic slot_free;
    logic item_on_board;
    logic gen_last;
  } stat_t;

  function automatic logic signed [POS_W-1:0] step_h(input logic [1:0] side);
    logic signed [POS_W-1:0] d;
    case (side)
      2'd0:    d = -POS_ONE;
      2'd1:    d = -POS_ONE;
      2'd2:    d = POS_ONE;
      default: d = POS_ONE;
    endcase
    return d;
  endfunction

  function automatic logic signed [POS_W-1:0] step_f(input logic [1:0] side);
    logic signed [POS_W-1:0] d;
    case (side)
      2'd0:    d = POS_ONE;
      2'd1:    d = -POS_ONE;
      2'd2:    d = -POS_ONE;
      default: d = POS_ONE;
    endcase
    return d;
  endfunction

endpackage

@@ sv/ong_ctrl.sv @@
// Controller state machine: board clearing pass, item intake and gather sequencing.
// Depends on ong_pkg (state_t, cmd_t, stat_t, opcode constants).
module ong_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_opcode,
  input  ong_pkg::stat_t stat,
  output ong_pkg::cmd_t  cmd
);

  ong_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ong_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ong_pkg::ST_CLEAR: begin
        if (stat.clear_done) state_next = ong_pkg::ST_IDLE;
      end
      ong_pkg::ST_IDLE: begin
        if (in_valid && stat.slot_free && in_opcode == ong_pkg::OP_QUERY &&
            stat.item_on_board) begin
          state_next = ong_pkg::ST_GATHER;
        end
      end
      ong_pkg::ST_GATHER: begin
        if (stat.slot_free && stat.gen_last) state_next = ong_pkg::ST_IDLE;
      end
      default: state_next = ong_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ong_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ong_pkg::ST_IDLE: begin
        cmd.in_ready = stat.slot_free;
        if (in_valid && stat.slot_free) begin
          if (in_opcode == ong_pkg::OP_WRITE) begin
            cmd.cell_write = stat.item_on_board;
          end else if (stat.item_on_board) begin
            cmd.load_query = 1'b1;
          end else begin
            cmd.push_bad = 1'b1;
          end
        end
      end
      ong_pkg::ST_GATHER: begin
        cmd.step = stat.slot_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ sv/ong_dpath.sv @@
// Datapath: board memory, octant fold, ring walker, read stage and output register.
// Depends on ong_pkg (item_t, cmd_t, stat_t, step tables, widths).
module ong_dpath #(
  parameter int MAX_BOARD  = ong_pkg::DEF_MAX_BOARD,
  parameter int RING_LIMIT = ong_pkg::DEF_RING_LIMIT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ong_pkg::cmd_t                   cmd,
  input  ong_pkg::item_t                  item,
  input  logic [ong_pkg::ROW_W-1:0]       size,
  input  logic [ong_pkg::COLOR_W-1:0]     empty_code,
  input  logic                            out_ready,
  output ong_pkg::stat_t                  stat,
  output logic                            out_valid,
  output logic [ong_pkg::COLOR_W-1:0]     out_color,
  output logic                            out_bad,
  output logic                            out_last
);

  localparam int DEPTH = MAX_BOARD * MAX_BOARD;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW    = AW + ong_pkg::ROW_W;
  localparam int PW    = ong_pkg::POS_W;
  localparam int RW    = ong_pkg::ROW_W;
  localparam int NW    = ong_pkg::RAD_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
  localparam logic [NW-1:0] RAD_MAX  = NW'(RING_LIMIT);

  logic [ong_pkg::COLOR_W-1:0] board [DEPTH];
  logic [ong_pkg::COLOR_W-1:0] rdata;

  logic [AW-1:0] clr_cnt;

  // query walker state
  logic signed [PW-1:0] pos_h, pos_f;
  logic [NW-1:0]        ring, rad, kk;
  logic [1:0]           side;
  logic                 flip_row, flip_col, swapped;

  // read stage
  logic s2_valid, s2_bad, s2_off, s2_last;
  logic s2_move;

  // intake decode
  logic                 item_on_board;
  logic [RW:0]          half;
  logic [RW:0]          frow_w, fcol_w;
  logic [RW-1:0]        frow, fcol;
  logic                 fl_row, fl_col;
  logic [RW-1:0]        wr_r, wr_c;
  logic [MW-1:0]        wr_addr_w;

  // walker mapping
  logic signed [PW-1:0] size_s, br0, bc0, br, bc;
  logic                 map_on;
  logic [RW-1:0]        rd_r, rd_c;
  logic [MW-1:0]        rd_addr_w;
  logic                 gen_last;

  always_comb begin
    item_on_board = item.cell_row >= RW'(1) && item.cell_row <= size &&
                    item.cell_col >= RW'(1) && item.cell_col <= size;
    half   = ({1'b0, size} + (RW+1)'(1)) >> 1;
    fl_row = {1'b0, item.cell_row} > half;
    fl_col = {1'b0, item.cell_col} > half;
    frow_w = fl_row ? ({1'b0, size} + (RW+1)'(1) - {1'b0, item.cell_row})
                    : {1'b0, item.cell_row};
    fcol_w = fl_col ? ({1'b0, size} + (RW+1)'(1) - {1'b0, item.cell_col})
                    : {1'b0, item.cell_col};
    frow   = frow_w[RW-1:0];
    fcol   = fcol_w[RW-1:0];
    wr_r   = item.cell_row - RW'(1);
    wr_c   = item.cell_col - RW'(1);
    wr_addr_w = MW'(wr_r) * MW'(MAX_BOARD) + MW'(wr_c);
  end

  always_comb begin
    size_s = signed'(PW'(size));
    br0    = swapped ? pos_f : pos_h;
    bc0    = swapped ? pos_h : pos_f;
    br     = flip_row ? (size_s + ong_pkg::POS_ONE - br0) : br0;
    bc     = flip_col ? (size_s + ong_pkg::POS_ONE - bc0) : bc0;
    map_on = br >= ong_pkg::POS_ONE && br <= size_s &&
             bc >= ong_pkg::POS_ONE && bc <= size_s;
    rd_r   = br[RW-1:0] - RW'(1);
    rd_c   = bc[RW-1:0] - RW'(1);
    rd_addr_w = MW'(rd_r) * MW'(MAX_BOARD) + MW'(rd_c);
    gen_last = (ring == rad) &&
               (ring == '0 || (side == ong_pkg::SIDE_LAST && kk == ring - NW'(1)));
  end

  // board memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      board[clr_cnt] <= '0;
    end else if (cmd.cell_write) begin
      board[wr_addr_w[AW-1:0]] <= item.cell_value;
    end
    if (cmd.step && map_on) begin
      rdata <= board[rd_addr_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr && clr_cnt != CLR_LAST) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      swapped  <= frow > fcol;
      pos_h    <= signed'(PW'((frow > fcol) ? fcol : frow));
      pos_f    <= signed'(PW'((frow > fcol) ? frow : fcol));
      flip_row <= fl_row;
      flip_col <= fl_col;
      rad      <= (item.radius > RAD_MAX) ? RAD_MAX : item.radius;
      ring     <= '0;
      side     <= '0;
      kk       <= '0;
    end else if (cmd.step && !gen_last) begin
      if (ring == '0) begin
        pos_h <= pos_h + ong_pkg::POS_ONE;
        ring  <= NW'(1);
        side  <= '0;
        kk    <= '0;
      end else if (kk == ring - NW'(1)) begin
        kk <= '0;
        if (side == ong_pkg::SIDE_LAST) begin
          pos_h <= pos_h + ong_pkg::POS_TWO;
          pos_f <= pos_f + ong_pkg::POS_ONE;
          ring  <= ring + NW'(1);
          side  <= '0;
        end else begin
          pos_h <= pos_h + ong_pkg::step_h(side);
          pos_f <= pos_f + ong_pkg::step_f(side);
          side  <= side + 2'd1;
        end
      end else begin
        pos_h <= pos_h + ong_pkg::step_h(side);
        pos_f <= pos_f + ong_pkg::step_f(side);
        kk    <= kk + NW'(1);
      end
    end
  end

  assign s2_move = s2_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (cmd.step || cmd.push_bad) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_bad) begin
      s2_bad  <= 1'b1;
      s2_off  <= 1'b0;
      s2_last <= 1'b1;
    end else if (cmd.step) begin
      s2_bad  <= 1'b0;
      s2_off  <= !map_on;
      s2_last <= gen_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_color <= s2_bad ? '0 : (s2_off ? empty_code : rdata);
      out_bad   <= s2_bad;
      out_last  <= s2_last;
    end
  end

  always_comb begin
    stat.clear_done    = clr_cnt == CLR_LAST;
    stat.slot_free     = !s2_valid || s2_move;
    stat.item_on_board = item_on_board;
    stat.gen_last      = gen_last;
  end

`ifndef SYNTHESIS
  a_push_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.push_bad) |-> (!s2_valid || s2_move))
    else $error("read stage overwritten while holding a result");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step && cmd.push_bad))
    else $error("walker step and bad-position push in the same cycle");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bad) |-> (out_last && out_color == '0))
    else $error("bad-position result not a single zero-colored last transfer");

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (ring <= rad && rad <= RAD_MAX))
    else $error("walker ring beyond requested radius");
`endif

endmodule

@@ sv/octant_neighborhood_gather_core.sv @@
// Octant neighborhood gather: after reset every cell of the board is cleared, during which
// no item is taken; configuration writes are taken at any time. A query of radius r is
// loaded into the walker, then steps through 1 + 2r(r+1) board positions (41 at r = 4),
// one per cycle while the output is taken, set by the single read port of the board
// memory; each read result passes through the read stage and the output register. A
// query of an off-board cell yields one flagged transfer. The input is held while a query
// is walked; the next item is accepted back in the idle state once the last position of
// the current query has been stepped and the read stage is free.
// Depends on ong_pkg, ong_ctrl and ong_dpath.
module octant_neighborhood_gather_core #(
  parameter int MAX_BOARD  = ong_pkg::DEF_MAX_BOARD,
  parameter int RING_LIMIT = ong_pkg::DEF_RING_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cell_row[4:0], cell_col[9:5], cell_value[11:10], radius[14:12]
  input  logic        s_tuser,   // opcode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // cell_color[1:0]
  output logic        m_tuser,   // bad_position[0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  logic [ong_pkg::ROW_W-1:0]   board_size;
  logic [ong_pkg::COLOR_W-1:0] empty_code;
  logic [ong_pkg::ROW_W-1:0]   size;
  logic [ong_pkg::COLOR_W-1:0] color;

  ong_pkg::item_t item;
  ong_pkg::cmd_t  cmd;
  ong_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_size <= ong_pkg::SIZE_RESET;
      empty_code <= ong_pkg::EMPTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ong_pkg::REG_BOARD_SIZE: board_size <= cfg_data;
        ong_pkg::REG_EMPTY_CODE: empty_code <= cfg_data[ong_pkg::COLOR_W-1:0];
        default: board_size <= board_size;
      endcase
    end
  end

  always_comb begin
    if (board_size == '0) begin
      size = ong_pkg::ROW_W'(1);
    end else if (board_size > ong_pkg::ROW_W'(MAX_BOARD)) begin
      size = ong_pkg::ROW_W'(MAX_BOARD);
    end else begin
      size = board_size;
    end
  end

  always_comb begin
    item.opcode     = s_tuser;
    item.cell_row   = s_tdata[4:0];
    item.cell_col   = s_tdata[9:5];
    item.cell_value = s_tdata[11:10];
    item.radius     = s_tdata[14:12];
  end

  ong_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_opcode (item.opcode),
    .stat      (stat),
    .cmd       (cmd)
  );

  ong_dpath #(
    .MAX_BOARD  (MAX_BOARD),
    .RING_LIMIT (RING_LIMIT)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .item       (item),
    .size       (size),
    .empty_code (empty_code),
    .out_ready  (m_tready),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_color  (color),
    .out_bad    (m_tuser),
    .out_last   (m_tlast)
  );

  assign s_tready = cmd.in_ready;
  assign m_tdata  = {6'b0, color};

endmodule
